### src/lpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lpa_pkg;

	localparam int PIXEL_COUNT = 16;
	localparam int PIX_W       = $clog2(PIXEL_COUNT);
	localparam int HEAD_W      = $clog2(2 * PIXEL_COUNT);
	localparam int SCAN_W      = PIX_W + 1;

	localparam logic [15:0] RESET_FRAME_PERIOD = 16'd20;
	localparam logic [31:0] RESET_RANDOM_SEED  = 32'd1;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_SET   = 2'd1,
		CMD_FLASH = 2'd2
	} command_t;

	typedef enum logic [3:0] {
		PAT_OFF     = 4'd0,
		PAT_IDLE    = 4'd1,
		PAT_ALERT   = 4'd2,
		PAT_SUCCESS = 4'd3,
		PAT_MISS    = 4'd4,
		PAT_ANGRY   = 4'd5,
		PAT_SCANNER = 4'd6,
		PAT_CHAOS   = 4'd7,
		PAT_SLEEP   = 4'd8,
		PAT_NORMAL  = 4'd9,
		PAT_ERROR   = 4'd10
	} pattern_t;

	typedef enum logic [0:0] {
		REG_FRAME_PERIOD = 1'b0,
		REG_RANDOM_SEED  = 1'b1
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHECK,
		ST_SETUP1,
		ST_SETUP2,
		ST_SETUP3,
		ST_SETUP4,
		ST_RAND,
		ST_PIXEL
	} state_t;

	typedef struct packed {
		logic take;
		logic exec;
		logic check;
		logic setup1;
		logic setup2;
		logic setup3;
		logic setup4;
		logic rand_step;
		logic emit;
	} lpa_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic frame_hit;
		logic chaos_fresh;
		logic last_pixel;
		logic rand_last;
		logic out_free;
	} lpa_status_t;

endpackage
`default_nettype wire

### src/lpa_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lpa_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [3:0]  pattern;
	logic [15:0] flash_duration_ms;

	modport source (output valid, command, pattern, flash_duration_ms, input ready);
	modport sink (input valid, command, pattern, flash_duration_ms, output ready);
endinterface

interface lpa_pixel_if;
	logic       valid;
	logic       ready;
	logic [5:0] pixel_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       last_pixel;

	modport source (output valid, pixel_index, red, green, blue, last_pixel, input ready);
	modport sink (input valid, pixel_index, red, green, blue, last_pixel, output ready);
endinterface
`default_nettype wire

### src/led_pattern_animator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// LED pattern animator. Requests on the item channel are millisecond ticks, pattern sets and
// pattern flashes; a tick that completes a frame period renders one frame and sends
// PIXEL_COUNT pixel requests, index 0 first, with last_pixel on the final one. The block
// takes one request at a time and sends one pixel a cycle from the single output register
// when the pixel side does not stall. On a chaos frame that draws new colours, the
// xorshift generator makes one step per cycle for red, green and blue in turn before each
// pixel is sent. The next request is taken while the final pixel still waits in the output
// register. Registers are written through write_enable, register_index and write_data; the
// user must write them only while idle, as the block itself does not enforce it.
module led_pattern_animator_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	lpa_item_if.sink          items,
	lpa_pixel_if.source       pixels,
	input  wire logic         write_enable,
	input  wire logic         register_index,
	input  wire logic [31:0]  write_data
);
	import lpa_pkg::*;

	lpa_cmd_t    cmd;
	lpa_status_t status;

	lpa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (items.valid),
		.item_ready (items.ready),
		.status     (status),
		.cmd        (cmd)
	);

	lpa_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.item_command    (items.command),
		.item_pattern    (items.pattern),
		.item_duration   (items.flash_duration_ms),
		.write_enable    (write_enable),
		.register_index  (register_index),
		.write_data      (write_data),
		.out_valid       (pixels.valid),
		.out_ready       (pixels.ready),
		.out_pixel_index (pixels.pixel_index),
		.out_red         (pixels.red),
		.out_green       (pixels.green),
		.out_blue        (pixels.blue),
		.out_last        (pixels.last_pixel)
	);

endmodule
`default_nettype wire

### src/lpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lpa_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire lpa_pkg::lpa_status_t status,
	output lpa_pkg::lpa_cmd_t        cmd
);
	import lpa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = status.is_tick ? ST_CHECK : ST_IDLE;
			end
			ST_CHECK: begin
				state_d = status.frame_hit ? ST_SETUP1 : ST_IDLE;
			end
			ST_SETUP1: state_d = ST_SETUP2;
			ST_SETUP2: state_d = ST_SETUP3;
			ST_SETUP3: state_d = ST_SETUP4;
			ST_SETUP4: begin
				state_d = status.chaos_fresh ? ST_RAND : ST_PIXEL;
			end
			ST_RAND: begin
				if (status.rand_last) state_d = ST_PIXEL;
			end
			ST_PIXEL: begin
				if (status.out_free) begin
					if (status.last_pixel) state_d = ST_IDLE;
					else if (status.chaos_fresh) state_d = ST_RAND;
					else state_d = ST_PIXEL;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.take   = item_valid;
			end
			ST_EXEC:   cmd.exec = 1'b1;
			ST_CHECK:  cmd.check = 1'b1;
			ST_SETUP1: cmd.setup1 = 1'b1;
			ST_SETUP2: cmd.setup2 = 1'b1;
			ST_SETUP3: cmd.setup3 = 1'b1;
			ST_SETUP4: cmd.setup4 = 1'b1;
			ST_RAND:   cmd.rand_step = 1'b1;
			ST_PIXEL:  cmd.emit = status.out_free;
			default: begin
				cmd        = '0;
				item_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

### src/lpa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module lpa_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lpa_pkg::lpa_cmd_t cmd,
	output lpa_pkg::lpa_status_t   status,
	input  wire logic [1:0]        item_command,
	input  wire logic [3:0]        item_pattern,
	input  wire logic [15:0]       item_duration,
	input  wire logic              write_enable,
	input  wire logic              register_index,
	input  wire logic [31:0]       write_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [5:0]             out_pixel_index,
	output logic [7:0]             out_red,
	output logic [7:0]             out_green,
	output logic [7:0]             out_blue,
	output logic                   out_last
);
	import lpa_pkg::*;

	function automatic logic [31:0] xorshift(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction

	// held request
	logic [1:0]  cmd_q;
	logic [3:0]  pat_q;
	logic [15:0] dur_q;

	logic [15:0] period_q;
	logic [31:0] rnd_q;
	logic [31:0] now_q;
	logic [31:0] elapsed_q;
	logic [31:0] deadline_q;
	logic [3:0]  active_q;
	logic [3:0]  restore_q;
	logic        frame_hit_q;

	logic [31:0]       fc_q;
	logic [7:0]        p160_q;
	logic [8:0]        p400_q;
	logic [3:0]        p10_q;
	logic [2:0]        p6_q;
	logic [5:0]        p40_q;
	logic [1:0]        p3_q;
	logic [HEAD_W-1:0] p2pc_q;

	logic [7:0]        t_idle_s1;
	logic [13:0]       x_sleep_s1;
	logic              alert_on_s1;
	logic              miss_on_s1;
	logic              first_half_s1;
	logic              error_on_s1;
	logic              chaos_fresh_s1;
	logic [HEAD_W-1:0] succ_head_s1;
	logic [PIX_W-1:0]  scan_head_s1;
	logic [7:0]        t_sleep_s2;
	logic [6:0]        v_idle_s2;
	logic [3:0]        v_sleep_s3;
	logic [7:0]        q_idle_s3;
	logic [5:0]        g_idle_s4;
	logic [2:0]        g_sleep_s4;

	logic [PIX_W-1:0] pix_q;
	logic [1:0]       sub_q;
	logic [7:0]       rnd_r_q;
	logic [7:0]       rnd_g_q;
	logic [7:0]       rnd_b_q;
	logic [23:0]      store_q [PIXEL_COUNT];

	logic        frames_clear;
	logic        flash_over;
	logic [31:0] elapsed_inc;
	logic [31:0] rnd_next;
	logic        last_pix;
	logic [7:0]  up160;
	logic [7:0]  up400;

	assign elapsed_inc = elapsed_q + 32'd1;
	assign rnd_next    = xorshift(rnd_q);
	assign last_pix    = (pix_q == PIX_W'(PIXEL_COUNT - 1));
	assign flash_over  = frame_hit_q && (deadline_q != 32'd0) && (now_q > deadline_q);

	always_comb begin
		frames_clear = 1'b0;
		if (cmd.exec) begin
			if (cmd_q == CMD_SET) frames_clear = (active_q != pat_q);
			else if (cmd_q == CMD_FLASH) frames_clear = 1'b1;
		end else if (cmd.check) begin
			frames_clear = flash_over;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cmd_q <= item_command;
			pat_q <= item_pattern;
			dur_q <= item_duration;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= RESET_FRAME_PERIOD;
			rnd_q    <= RESET_RANDOM_SEED;
		end else begin
			if (write_enable && register_index == REG_FRAME_PERIOD) begin
				period_q <= write_data[15:0];
			end
			if (write_enable && register_index == REG_RANDOM_SEED) begin
				rnd_q <= write_data;
			end else if (cmd.rand_step) begin
				rnd_q <= rnd_next;
			end
		end
	end

	// pattern selection, flash and frame timing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			elapsed_q   <= '0;
			deadline_q  <= '0;
			active_q    <= PAT_OFF;
			restore_q   <= PAT_OFF;
			frame_hit_q <= 1'b0;
		end else if (cmd.exec) begin
			case (cmd_q)
				CMD_SET: begin
					if (active_q != pat_q) begin
						active_q  <= pat_q;
						restore_q <= pat_q;
					end
				end
				CMD_FLASH: begin
					if (deadline_q == 32'd0) restore_q <= active_q;
					active_q   <= pat_q;
					deadline_q <= now_q + {16'd0, dur_q};
				end
				CMD_TICK: begin
					now_q <= now_q + 32'd1;
					if (elapsed_inc < {16'd0, period_q}) begin
						elapsed_q   <= elapsed_inc;
						frame_hit_q <= 1'b0;
					end else begin
						elapsed_q   <= '0;
						frame_hit_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end else if (cmd.check && flash_over) begin
			deadline_q <= '0;
			active_q   <= restore_q;
		end
	end

	// frame number and its phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q   <= '0;
			p160_q <= '0;
			p400_q <= '0;
			p10_q  <= '0;
			p6_q   <= '0;
			p40_q  <= '0;
			p3_q   <= '0;
			p2pc_q <= '0;
		end else if (frames_clear || (cmd.setup4 && fc_q == 32'hFFFF_FFFF)) begin
			fc_q   <= '0;
			p160_q <= '0;
			p400_q <= '0;
			p10_q  <= '0;
			p6_q   <= '0;
			p40_q  <= '0;
			p3_q   <= '0;
			p2pc_q <= '0;
		end else if (cmd.setup4) begin
			fc_q   <= fc_q + 32'd1;
			p160_q <= (p160_q == 8'd159) ? 8'd0 : p160_q + 8'd1;
			p400_q <= (p400_q == 9'd399) ? 9'd0 : p400_q + 9'd1;
			p10_q  <= (p10_q == 4'd9) ? 4'd0 : p10_q + 4'd1;
			p6_q   <= (p6_q == 3'd5) ? 3'd0 : p6_q + 3'd1;
			p40_q  <= (p40_q == 6'd39) ? 6'd0 : p40_q + 6'd1;
			p3_q   <= (p3_q == 2'd2) ? 2'd0 : p3_q + 2'd1;
			p2pc_q <= (p2pc_q == HEAD_W'(2 * PIXEL_COUNT - 1)) ? '0 : p2pc_q + HEAD_W'(1);
		end
	end

	assign up160 = (p160_q < 8'd80) ? p160_q : 8'd160 - p160_q;
	assign up400 = (p400_q < 9'd200) ? p400_q[7:0] : 8'(9'd400 - p400_q);

	// per-frame values, computed in the setup steps with constant multiplies
	always_ff @(posedge clk) begin
		if (cmd.setup1) begin
			t_idle_s1      <= 8'((12'(up160) * 12'd51) >> 4);
			x_sleep_s1     <= 14'(up400) * 14'd51;
			alert_on_s1    <= ~fc_q[2];
			miss_on_s1     <= (p10_q < 4'd5);
			first_half_s1  <= (p6_q < 3'd3);
			error_on_s1    <= (p40_q < 6'd4) || (p40_q >= 6'd8 && p40_q < 6'd12);
			chaos_fresh_s1 <= (active_q == PAT_CHAOS) && (p3_q == 2'd0);
			succ_head_s1   <= p2pc_q;
			scan_head_s1   <= PIX_W'(p2pc_q >> 1);
		end
		if (cmd.setup2) begin
			t_sleep_s2 <= 8'((23'(x_sleep_s1 >> 3) * 23'd3277) >> 14);
			v_idle_s2  <= 7'd25 + 7'((16'(t_idle_s1) * 16'd171) >> 10);
		end
		if (cmd.setup3) begin
			v_sleep_s3 <= 4'd3 + 4'((14'(t_sleep_s2 >> 2) * 14'd205) >> 10);
			q_idle_s3  <= 8'((10'(v_idle_s2) * 10'd11) >> 2);
		end
		if (cmd.setup4) begin
			g_idle_s4  <= 6'((16'(q_idle_s3) * 16'd205) >> 10);
			g_sleep_s4 <= 3'((12'(v_sleep_s3) * 12'd171) >> 9);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
			sub_q <= '0;
		end else if (cmd.setup4) begin
			pix_q <= '0;
			sub_q <= '0;
		end else begin
			if (cmd.rand_step) sub_q <= (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
			if (cmd.emit && !last_pix) pix_q <= pix_q + PIX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rand_step) begin
			case (sub_q)
				2'd0:    rnd_r_q <= rnd_next[7:0];
				2'd1:    rnd_g_q <= rnd_next[7:0];
				default: rnd_b_q <= rnd_next[7:0];
			endcase
		end
	end

	// colour of the current pixel
	logic [7:0]        col_r;
	logic [7:0]        col_g;
	logic [7:0]        col_b;
	logic [SCAN_W-1:0] d_raw;
	logic [SCAN_W-1:0] scan_dist;
	logic              angry_on;

	always_comb begin
		if (pix_q > scan_head_s1) d_raw = SCAN_W'(pix_q - scan_head_s1);
		else d_raw = SCAN_W'(scan_head_s1 - pix_q);
		if (d_raw > SCAN_W'(PIXEL_COUNT / 2)) scan_dist = SCAN_W'(PIXEL_COUNT) - d_raw;
		else scan_dist = d_raw;
		angry_on = (pix_q[0] == 1'b0) == first_half_s1;
	end

	always_comb begin
		col_r = 8'd0;
		col_g = 8'd0;
		col_b = 8'd0;
		unique case (active_q)
			PAT_IDLE: begin
				col_r = {1'b0, v_idle_s2};
				col_g = {2'b00, g_idle_s4};
				col_b = 8'd6;
			end
			PAT_ALERT: begin
				col_r = alert_on_s1 ? 8'd255 : 8'd40;
				col_g = alert_on_s1 ? 8'd178 : 8'd28;
			end
			PAT_SUCCESS: begin
				if (HEAD_W'(pix_q) <= succ_head_s1) begin
					col_g = 8'd200;
					col_b = 8'd25;
				end else begin
					col_g = 8'd20;
					col_b = 8'd2;
				end
			end
			PAT_MISS: col_r = miss_on_s1 ? 8'd255 : 8'd0;
			PAT_ANGRY: begin
				col_r = angry_on ? 8'd255 : 8'd90;
				col_g = angry_on ? 8'd30 : 8'd0;
			end
			PAT_SCANNER: begin
				if (scan_dist == SCAN_W'(0)) begin
					col_r = 8'd76;
					col_b = 8'd230;
				end else if (scan_dist == SCAN_W'(1)) begin
					col_r = 8'd53;
					col_b = 8'd160;
				end else if (scan_dist == SCAN_W'(2)) begin
					col_r = 8'd30;
					col_b = 8'd90;
				end else begin
					col_r = 8'd4;
					col_b = 8'd12;
				end
			end
			PAT_CHAOS: begin
				if (chaos_fresh_s1) begin
					col_r = rnd_r_q;
					col_g = rnd_g_q;
					col_b = rnd_b_q;
				end else begin
					col_r = store_q[pix_q][23:16];
					col_g = store_q[pix_q][15:8];
					col_b = store_q[pix_q][7:0];
				end
			end
			PAT_SLEEP: begin
				col_g = {5'd0, g_sleep_s4};
				col_b = {4'd0, v_sleep_s3};
			end
			PAT_NORMAL: begin
				col_r = 8'd200;
				col_g = 8'd200;
				col_b = 8'd190;
			end
			PAT_ERROR: begin
				col_r = error_on_s1 ? 8'd255 : 8'd0;
				col_g = error_on_s1 ? 8'd120 : 8'd0;
			end
			default: begin
				col_r = 8'd0;
				col_g = 8'd0;
				col_b = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PIXEL_COUNT; k++) store_q[k] <= '0;
		end else if (cmd.emit) begin
			store_q[pix_q] <= {col_r, col_g, col_b};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_pixel_index <= 6'(pix_q);
			out_red         <= col_r;
			out_green       <= col_g;
			out_blue        <= col_b;
			out_last        <= last_pix;
		end
	end

	always_comb begin
		status.is_tick     = (cmd_q == CMD_TICK);
		status.frame_hit   = frame_hit_q;
		status.chaos_fresh = chaos_fresh_s1;
		status.last_pixel  = last_pix;
		status.rand_last   = (sub_q == 2'd2);
		status.out_free    = !out_valid || out_ready;
	end

endmodule
`default_nettype wire
